// ===== rtl/core/vvr_pkg.sv =====
// Shared constants, pipeline types and arithmetic helpers for the
// vector-to-vector rotation matrix pipeline. No dependencies.
`timescale 1ns / 1ps

package vvr_pkg;

  localparam int FRAC_BITS = 14;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int HALF      = 1 << (FRAC_BITS - 1);
  localparam int THR_W     = 11;
  localparam int THR_RESET = 2;

  // One digit of the restoring square root: value, partial remainder, root.
  typedef struct packed {
    logic [63:0] v;
    logic [35:0] r;
    logic [31:0] q;
  } sq_t;

  // Values carried alongside the square root stages.
  typedef struct packed {
    logic signed [19:0] cos;
    logic signed [32:0] c0;
    logic signed [32:0] c1;
    logic signed [32:0] c2;
    logic signed [16:0] p0;
    logic signed [16:0] p1;
    logic signed [16:0] p2;
  } pay_t;

  // One stage of the three-lane restoring divider.
  typedef struct packed {
    logic [2:0][46:0] rem;
    logic [2:0]       neg;
    logic [2:0][14:0] q;
    logic [2:0]       ovf;
    logic [31:0]      den;
    logic             kz;
    logic             ident;
    logic signed [15:0] cosc;
    logic [15:0]      sinc;
  } dv_t;

  // Drop FRAC_BITS fraction bits, rounding halves away from zero.
  function automatic logic signed [47:0] rnd_shift(input logic signed [47:0] v);
    logic [47:0] mag;
    logic [47:0] r;
    mag = v[47] ? 48'(-v) : 48'(v);
    r   = (mag + 48'(HALF)) >> FRAC_BITS;
    return v[47] ? $signed(48'(-r)) : $signed(r);
  endfunction

  // Produce one root bit from the top two bits of the value.
  function automatic sq_t sqrt_step(input sq_t s);
    sq_t o;
    logic [35:0] r2;
    logic [35:0] t;
    r2 = {s.r[33:0], s.v[63:62]};
    t  = {2'b00, s.q, 2'b01};
    o.v = s.v << 2;
    if (r2 >= t) begin
      o.r = r2 - t;
      o.q = {s.q[30:0], 1'b1};
    end else begin
      o.r = r2;
      o.q = {s.q[30:0], 1'b0};
    end
    return o;
  endfunction

endpackage

// ===== rtl/core/vector_to_vector_rotation_matrix_top.sv =====
// Rotation matrix that turns unit vector from onto unit vector to, fully pipelined.
// Depends on vvr_pkg (constants, stage types, rounding and square root helpers).
`timescale 1ns / 1ps

// Throughput: one transaction per cycle; the whole pipeline advances together and
// holds in place while the output register is valid and not taken.
// Most of the depth lies in the 32-stage square root and the 16-stage divider.
// Reset: rst_ni clears all valid bits and loads collinear_threshold with 2.
module vector_to_vector_rotation_matrix_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [10:0]  cfg_wdata_i,     // collinear_threshold
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,    // from_x, from_y, from_z, to_x, to_y, to_z
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [143:0] m_axis_tdata     // m00, m01, m02, m10, m11, m12, m20, m21, m22
);

  localparam int NumStages = 57;
  localparam logic signed [19:0] OneC   = 20'(vvr_pkg::ONE);
  localparam logic signed [19:0] NegOne = -OneC;
  localparam logic signed [16:0] One17  = 17'(vvr_pkg::ONE);
  localparam logic signed [18:0] One19  = 19'(vvr_pkg::ONE);
  localparam logic signed [18:0] Neg19  = -One19;

  logic [vvr_pkg::THR_W-1:0] thr_q;
  logic [NumStages-1:0]      vld_q;
  logic                      en;

  // Advance whenever the output register is empty or being taken.
  assign en            = !vld_q[NumStages-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= vvr_pkg::THR_W'(vvr_pkg::THR_RESET);
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NumStages-2:0], s_axis_tvalid};
    end
  end

  // ---------------- Stage 1: the nine input products ----------------
  logic signed [15:0] a_in [3];
  logic signed [15:0] b_in [3];
  logic signed [31:0] s1_dot_q [3];
  logic signed [31:0] s1_cr_q [6];
  logic signed [15:0] s1_a_q [3];

  assign a_in[0] = s_axis_tdata[15:0];
  assign a_in[1] = s_axis_tdata[31:16];
  assign a_in[2] = s_axis_tdata[47:32];
  assign b_in[0] = s_axis_tdata[63:48];
  assign b_in[1] = s_axis_tdata[79:64];
  assign b_in[2] = s_axis_tdata[95:80];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_dot_q[i] <= a_in[i] * b_in[i];
        s1_a_q[i]   <= a_in[i];
      end
      s1_cr_q[0] <= a_in[1] * b_in[2];
      s1_cr_q[1] <= a_in[2] * b_in[1];
      s1_cr_q[2] <= a_in[2] * b_in[0];
      s1_cr_q[3] <= a_in[0] * b_in[2];
      s1_cr_q[4] <= a_in[0] * b_in[1];
      s1_cr_q[5] <= a_in[1] * b_in[0];
    end
  end

  // ---------------- Stage 2: cosine, cross product, fallback axis ----------------
  vvr_pkg::pay_t      s2_d, s2_q;
  logic signed [33:0] dot34;
  logic signed [16:0] ae [3];
  logic [16:0]        am [3];

  always_comb begin
    dot34   = 34'(s1_dot_q[0]) + 34'(s1_dot_q[1]) + 34'(s1_dot_q[2]);
    s2_d.cos = 20'(vvr_pkg::rnd_shift(48'(dot34)));
    s2_d.c0 = 33'(s1_cr_q[0]) - 33'(s1_cr_q[1]);
    s2_d.c1 = 33'(s1_cr_q[2]) - 33'(s1_cr_q[3]);
    s2_d.c2 = 33'(s1_cr_q[4]) - 33'(s1_cr_q[5]);
    for (int i = 0; i < 3; i++) begin
      ae[i] = 17'(s1_a_q[i]);
      am[i] = ae[i][16] ? 17'(-ae[i]) : 17'(ae[i]);
    end
    // Cross with the basis vector of the smallest component; y beats z on a tie.
    if (am[0] <= am[1] && am[0] <= am[2]) begin
      s2_d.p0 = '0;     s2_d.p1 = ae[2];  s2_d.p2 = -ae[1];
    end else if (am[0] > am[1] && am[1] <= am[2]) begin
      s2_d.p0 = -ae[2]; s2_d.p1 = '0;     s2_d.p2 = ae[0];
    end else begin
      s2_d.p0 = ae[1];  s2_d.p1 = -ae[0]; s2_d.p2 = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) s2_q <= s2_d;
  end

  // ---------------- Stage 3: squares ----------------
  vvr_pkg::pay_t      s3_q;
  logic signed [32:0] cs [3];
  logic signed [16:0] ps [3];
  logic [31:0]        cm [3];
  logic [16:0]        pm [3];
  logic [63:0]        s3_sqc_q [3];
  logic [33:0]        s3_sqp_q [3];

  always_comb begin
    cs[0] = s2_q.c0; cs[1] = s2_q.c1; cs[2] = s2_q.c2;
    ps[0] = s2_q.p0; ps[1] = s2_q.p1; ps[2] = s2_q.p2;
    for (int i = 0; i < 3; i++) begin
      cm[i] = cs[i][32] ? 32'(-cs[i]) : 32'(cs[i]);
      pm[i] = ps[i][16] ? 17'(-ps[i]) : 17'(ps[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_q <= s2_q;
      for (int i = 0; i < 3; i++) begin
        s3_sqc_q[i] <= cm[i] * cm[i];
        s3_sqp_q[i] <= pm[i] * pm[i];
      end
    end
  end

  // ---------------- Stage 4 and square root stages ----------------
  vvr_pkg::sq_t  sqc_q [33];
  vvr_pkg::sq_t  sqp_q [33];
  vvr_pkg::pay_t pay_q [33];
  logic [35:0]   sump;

  assign sump = 36'(s3_sqp_q[0]) + 36'(s3_sqp_q[1]) + 36'(s3_sqp_q[2]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqc_q[0].v <= s3_sqc_q[0] + s3_sqc_q[1] + s3_sqc_q[2];
      sqc_q[0].r <= '0;
      sqc_q[0].q <= '0;
      sqp_q[0].v <= 64'(sump);
      sqp_q[0].r <= '0;
      sqp_q[0].q <= '0;
      pay_q[0]   <= s3_q;
    end
  end

  // One root bit per stage for both the cross length and the fallback length.
  for (genvar k = 0; k < 32; k++) begin : g_sqrt
    always_ff @(posedge clk_i) begin
      if (en) begin
        sqc_q[k+1] <= vvr_pkg::sqrt_step(sqc_q[k]);
        sqp_q[k+1] <= vvr_pkg::sqrt_step(sqp_q[k]);
        pay_q[k+1] <= pay_q[k];
      end
    end
  end

  // ---------------- Decision stage: collinear test, divider operands ----------------
  vvr_pkg::dv_t       dv_q [17];
  vvr_pkg::dv_t       dv_d [17];
  logic [31:0]        s2w;
  logic [31:0]        den;
  logic [18:0]        sinq;
  logic               col;
  logic               opp;
  logic signed [32:0] num [3];
  logic [31:0]        nm [3];

  always_comb begin
    s2w  = sqc_q[32].q;
    sinq = 19'((33'(s2w) + 33'(vvr_pkg::HALF)) >> vvr_pkg::FRAC_BITS);
    col  = (s2w == '0) || (sinq < 19'(thr_q));
    opp  = col && pay_q[32].cos[19];
    den  = opp ? sqp_q[32].q : s2w;
    num[0] = opp ? 33'(pay_q[32].p0) : pay_q[32].c0;
    num[1] = opp ? 33'(pay_q[32].p1) : pay_q[32].c1;
    num[2] = opp ? 33'(pay_q[32].p2) : pay_q[32].c2;
    dv_d[0] = '0;
    for (int i = 0; i < 3; i++) begin
      nm[i] = num[i][32] ? 32'(-num[i]) : 32'(num[i]);
      dv_d[0].rem[i] = (47'(nm[i]) << vvr_pkg::FRAC_BITS) + 47'(den >> 1);
      dv_d[0].neg[i] = num[i][32];
    end
    dv_d[0].den   = den;
    dv_d[0].kz    = (den == '0);
    dv_d[0].ident = col && !pay_q[32].cos[19];
    if (pay_q[32].cos > OneC) begin
      dv_d[0].cosc = 16'(OneC);
    end else if (pay_q[32].cos < NegOne) begin
      dv_d[0].cosc = 16'(NegOne);
    end else begin
      dv_d[0].cosc = 16'(pay_q[32].cos);
    end
    dv_d[0].sinc = (sinq > 19'(vvr_pkg::ONE)) ? 16'(vvr_pkg::ONE) : 16'(sinq);
  end

  // First divider stage flags a quotient of 2^15 or more; it will saturate anyway.
  always_comb begin
    dv_d[1] = dv_q[0];
    for (int i = 0; i < 3; i++) begin
      dv_d[1].ovf[i] = (dv_q[0].rem[i][46:15] >= dv_q[0].den);
    end
  end

  // Remaining stages: one quotient bit per lane, most significant first.
  for (genvar j = 2; j < 17; j++) begin : g_div
    localparam int B = 16 - j;
    logic [46:0] dsh;
    always_comb begin
      dsh     = 47'(dv_q[j-1].den) << B;
      dv_d[j] = dv_q[j-1];
      for (int i = 0; i < 3; i++) begin
        if (dv_q[j-1].rem[i] >= dsh) begin
          dv_d[j].rem[i]  = dv_q[j-1].rem[i] - dsh;
          dv_d[j].q[i][B] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 17; j++) dv_q[j] <= dv_d[j];
    end
  end

  // ---------------- K stage: saturate and sign the axis ----------------
  logic signed [15:0] k_d [3];
  logic signed [15:0] k_q [3];
  logic [15:0]        qs [3];
  logic               k_ident_q;
  logic signed [15:0] k_cos_q;
  logic [15:0]        k_sin_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_q[16].ovf[i] || dv_q[16].q[i] > 15'(vvr_pkg::ONE)) begin
        qs[i] = 16'(vvr_pkg::ONE);
      end else begin
        qs[i] = 16'(dv_q[16].q[i]);
      end
      if (dv_q[16].kz) begin
        k_d[i] = '0;
      end else begin
        k_d[i] = dv_q[16].neg[i] ? $signed(16'(-qs[i])) : $signed(qs[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) k_q[i] <= k_d[i];
      k_ident_q <= dv_q[16].ident;
      k_cos_q   <= dv_q[16].cosc;
      k_sin_q   <= dv_q[16].sinc;
    end
  end

  // ---------------- M1: t*k and s*k ----------------
  logic signed [16:0] t17;
  logic signed [16:0] s17;
  logic signed [47:0] tp48 [3];
  logic signed [47:0] sp48 [3];
  logic signed [17:0] m1_tk_q [3];
  logic signed [17:0] m1_sk_q [3];
  logic signed [15:0] m1_k_q [3];
  logic               m1_ident_q;
  logic signed [15:0] m1_cos_q;

  always_comb begin
    t17 = One17 - 17'(k_cos_q);
    s17 = $signed({1'b0, k_sin_q});
    for (int i = 0; i < 3; i++) begin
      tp48[i] = t17 * k_q[i];
      sp48[i] = s17 * k_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m1_tk_q[i] <= 18'(vvr_pkg::rnd_shift(tp48[i]));
        m1_sk_q[i] <= 18'(vvr_pkg::rnd_shift(sp48[i]));
        m1_k_q[i]  <= k_q[i];
      end
      m1_ident_q <= k_ident_q;
      m1_cos_q   <= k_cos_q;
    end
  end

  // ---------------- M2: (t*k_r)*k_c ----------------
  logic signed [47:0] pp48 [9];
  logic signed [17:0] m2_pr_q [9];
  logic signed [17:0] m2_sk_q [3];
  logic               m2_ident_q;
  logic signed [15:0] m2_cos_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        pp48[r*3+c] = m1_tk_q[r] * m1_k_q[c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 9; i++) m2_pr_q[i] <= 18'(vvr_pkg::rnd_shift(pp48[i]));
      for (int i = 0; i < 3; i++) m2_sk_q[i] <= m1_sk_q[i];
      m2_ident_q <= m1_ident_q;
      m2_cos_q   <= m1_cos_q;
    end
  end

  // ---------------- M3: add the cosine and sine terms, saturate ----------------
  logic signed [18:0] msum [9];
  logic [15:0]        mo [9];
  logic [143:0]       out_d;
  logic [143:0]       out_q;

  always_comb begin
    msum[0] = 19'(m2_pr_q[0]) + 19'(m2_cos_q);
    msum[1] = 19'(m2_pr_q[1]) + 19'(m2_sk_q[2]);
    msum[2] = 19'(m2_pr_q[2]) - 19'(m2_sk_q[1]);
    msum[3] = 19'(m2_pr_q[3]) - 19'(m2_sk_q[2]);
    msum[4] = 19'(m2_pr_q[4]) + 19'(m2_cos_q);
    msum[5] = 19'(m2_pr_q[5]) + 19'(m2_sk_q[0]);
    msum[6] = 19'(m2_pr_q[6]) + 19'(m2_sk_q[1]);
    msum[7] = 19'(m2_pr_q[7]) - 19'(m2_sk_q[0]);
    msum[8] = 19'(m2_pr_q[8]) + 19'(m2_cos_q);
    for (int i = 0; i < 9; i++) begin
      if (m2_ident_q) begin
        mo[i] = (i % 4 == 0) ? 16'(vvr_pkg::ONE) : '0;
      end else if (msum[i] > One19) begin
        mo[i] = 16'(One19);
      end else if (msum[i] < Neg19) begin
        mo[i] = 16'(Neg19);
      end else begin
        mo[i] = 16'(msum[i]);
      end
      out_d[i*16 +: 16] = mo[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= out_d;
  end

  assign m_axis_tdata = out_q;

`ifndef SYNTHESIS
  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> vld_q[0])
    else $error("accepted transaction did not enter the pipeline");

  a_m00_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[15:0]) <= $signed(16'(vvr_pkg::ONE)) &&
                       $signed(m_axis_tdata[15:0]) >= -$signed(16'(vvr_pkg::ONE))))
    else $error("m00 outside saturation range");

  a_m22_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[143:128]) <= $signed(16'(vvr_pkg::ONE)) &&
                       $signed(m_axis_tdata[143:128]) >= -$signed(16'(vvr_pkg::ONE))))
    else $error("m22 outside saturation range");
`endif

endmodule

// ===== tb/vector_to_vector_rotation_matrix_checker.sv =====
// Scoreboard for the rotation matrix block: watches both stream channels,
// predicts each matrix from the input vector pair and compares field by field.
// Depends on vvr_pkg for FRAC_BITS and the threshold width and reset value.
`timescale 1ns / 1ps

module vector_to_vector_rotation_matrix_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [10:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [143:0] m_axis_tdata,
  output int           fail_count_o,
  output int           pending_o,
  output int           matrix_count_o
);
  import vvr_pkg::*;

  localparam longint ONE_Q = longint'(1) << FRAC_BITS;

  logic [THR_W-1:0] threshold_q;
  logic [143:0]     matrix_q[$];

  assign pending_o = matrix_q.size();

  function automatic longint round_q(longint v);
    longint mag;
    mag = v < 0 ? -v : v;
    mag = (mag + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    return v < 0 ? -mag : mag;
  endfunction

  function automatic longint round_div(longint num, longint den);
    longint mag;
    mag = num < 0 ? -num : num;
    mag = (mag + den / 2) / den;
    return num < 0 ? -mag : mag;
  endfunction

  // Floor square root by bisection on the 64-bit unsigned value.
  function automatic longint floor_sqrt(logic [63:0] v);
    logic [63:0] lo, hi, mid;
    lo = 0;
    hi = 64'd4294967296;
    while (hi - lo > 1) begin
      mid = (lo + hi) >> 1;
      if (mid * mid <= v) lo = mid;
      else hi = mid;
    end
    return longint'(lo);
  endfunction

  function automatic longint sat_one(longint v);
    if (v > ONE_Q) return ONE_Q;
    if (v < -ONE_Q) return -ONE_Q;
    return v;
  endfunction

  function automatic longint mul_q(longint a, longint b);
    return round_q(a * b);
  endfunction

  function automatic logic [143:0] rotation_matrix(logic [95:0] d, logic [THR_W-1:0] thr);
    longint a[3], b[3], c[3], k[3], p[3], m[9];
    longint cosv, sinv, t, s2, len, ax, ay, az;
    logic [63:0] sum;
    logic [143:0] res;
    int sel;
    for (int i = 0; i < 3; i++) begin
      a[i] = longint'($signed(d[16*i +: 16]));
      b[i] = longint'($signed(d[16*(i+3) +: 16]));
    end
    cosv = round_q(a[0]*b[0] + a[1]*b[1] + a[2]*b[2]);
    c[0] = a[1]*b[2] - a[2]*b[1];
    c[1] = a[2]*b[0] - a[0]*b[2];
    c[2] = a[0]*b[1] - a[1]*b[0];
    sum = 0;
    for (int i = 0; i < 3; i++) sum += 64'(c[i] * c[i]);
    s2 = floor_sqrt(sum);
    sinv = round_q(s2);
    if (s2 == 0 || sinv < longint'(thr)) begin
      if (cosv >= 0) begin
        res = '0;
        for (int i = 0; i < 9; i += 4) res[16*i +: 16] = 16'(ONE_Q);
        return res;
      end
      ax = a[0] < 0 ? -a[0] : a[0];
      ay = a[1] < 0 ? -a[1] : a[1];
      az = a[2] < 0 ? -a[2] : a[2];
      sel = ax <= ay ? (ax <= az ? 0 : 2) : (ay <= az ? 1 : 2);
      case (sel)
        0: begin p[0] = 0; p[1] = a[2]; p[2] = -a[1]; end
        1: begin p[0] = -a[2]; p[1] = 0; p[2] = a[0]; end
        default: begin p[0] = a[1]; p[1] = -a[0]; p[2] = 0; end
      endcase
      len = floor_sqrt(64'(p[0]*p[0] + p[1]*p[1] + p[2]*p[2]));
      for (int i = 0; i < 3; i++)
        k[i] = len == 0 ? 0 : sat_one(round_div(p[i] * ONE_Q, len));
    end else begin
      for (int i = 0; i < 3; i++) k[i] = sat_one(round_div(c[i] * ONE_Q, s2));
    end
    cosv = sat_one(cosv);
    if (sinv > ONE_Q) sinv = ONE_Q;
    t = ONE_Q - cosv;
    m[0] = mul_q(mul_q(t, k[0]), k[0]) + cosv;
    m[1] = mul_q(mul_q(t, k[0]), k[1]) + mul_q(sinv, k[2]);
    m[2] = mul_q(mul_q(t, k[0]), k[2]) - mul_q(sinv, k[1]);
    m[3] = mul_q(mul_q(t, k[1]), k[0]) - mul_q(sinv, k[2]);
    m[4] = mul_q(mul_q(t, k[1]), k[1]) + cosv;
    m[5] = mul_q(mul_q(t, k[1]), k[2]) + mul_q(sinv, k[0]);
    m[6] = mul_q(mul_q(t, k[2]), k[0]) + mul_q(sinv, k[1]);
    m[7] = mul_q(mul_q(t, k[2]), k[1]) - mul_q(sinv, k[0]);
    m[8] = mul_q(mul_q(t, k[2]), k[2]) + cosv;
    for (int i = 0; i < 9; i++) res[16*i +: 16] = 16'(sat_one(m[i]));
    return res;
  endfunction

  task automatic report_mismatch(string what, int idx, logic [15:0] got, logic [15:0] want);
    $display("%0t mismatch %s m%0d%0d: got %0d want %0d", $time, what, idx / 3, idx % 3,
             $signed(got), $signed(want));
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    matrix_count_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    logic [143:0] want;
    if (!rst_ni) begin
      threshold_q <= THR_W'(THR_RESET);
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        matrix_q.push_back(rotation_matrix(s_axis_tdata, threshold_q));
      if (m_axis_tvalid && m_axis_tready) begin
        matrix_count_o++;
        if (matrix_q.size() == 0) begin
          $display("%0t unexpected output transaction", $time);
          fail_count_o++;
        end else begin
          want = matrix_q.pop_front();
          for (int i = 0; i < 9; i++)
            if (m_axis_tdata[16*i +: 16] !== want[16*i +: 16])
              report_mismatch("field", i, m_axis_tdata[16*i +: 16], want[16*i +: 16]);
        end
      end
      if (cfg_we_i) threshold_q <= cfg_wdata_i;
    end
  end

endmodule

// ===== tb/vector_to_vector_rotation_matrix_top_tb.sv =====
// Top of the rotation matrix testbench: clock, reset, stimulus and verdict.
// Depends on vvr_pkg, the block and vector_to_vector_rotation_matrix_checker.
`timescale 1ns / 1ps

module vector_to_vector_rotation_matrix_top_tb;
  import vvr_pkg::*;

  localparam int  LATENCY     = 57;
  localparam int  RANDOM_ITEMS = 1500;
  localparam longint CYCLE_LIMIT = 400000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [10:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [143:0] m_axis_tdata;

  int     fail_count, pending, matrix_count;
  longint cycle_count = 0;
  bit     hold_off_req = 1'b0;   // sink holds tready low while set
  bit     stim_done = 1'b0;

  vector_to_vector_rotation_matrix_top uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  vector_to_vector_rotation_matrix_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending), .matrix_count_o(matrix_count)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Draw a gap length: mostly none or short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Unit-ish component in Q2.14, sometimes the full range of the field.
  function automatic logic [15:0] rand_comp();
    if ($urandom_range(9) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  // Hand one transaction to the block and wait until it is taken.
  task automatic send_pair(logic [95:0] data);
    int gap;
    gap = stim_done ? 0 : gap_len();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic send_vectors(int fx, int fy, int fz, int tx, int ty, int tz);
    send_pair({16'(tz), 16'(ty), 16'(tx), 16'(fz), 16'(fy), 16'(fx)});
  endtask

  // Drop valid, drain every expected matrix, let the pipe settle, then write.
  task automatic quiesce_and_config(logic [10:0] thr);
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= thr;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Random pair in one of several shapes: general, near-same, near-opposite, noise.
  task automatic send_random_pair();
    logic [15:0] f[3], t[3];
    int kind;
    kind = $urandom_range(9);
    for (int i = 0; i < 3; i++) f[i] = rand_comp();
    for (int i = 0; i < 3; i++) begin
      case (kind)
        0, 1: t[i] = f[i] + 16'($signed($urandom_range(0, 8)) - 4);
        2, 3: t[i] = -f[i] + 16'($signed($urandom_range(0, 8)) - 4);
        4:    t[i] = 16'($urandom);
        default: t[i] = rand_comp();
      endcase
    end
    if (kind == 4) f[$urandom_range(2)] = 16'($urandom);
    send_pair({t[2], t[1], t[0], f[2], f[1], f[0]});
  endtask

  // Sink: random stalls, plus a long hold-off on request.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
      end else if (stim_done) begin
        m_axis_tready <= 1'b1;
      end else begin
        gap = gap_len();
        if (gap != 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap - 1) @(negedge clk_i);
          @(negedge clk_i);
        end
        m_axis_tready <= 1'b1;
        // keep a run of back-to-back acceptance now and then
        if ($urandom_range(7) == 0) repeat ($urandom_range(10, 60)) @(negedge clk_i);
      end
    end
  end

  // Long receiver stall, counted in cycles, while the sender keeps offering.
  // Start it in the middle of the second random phase so the sender is busy.
  initial begin
    @(posedge rst_ni);
    wait (matrix_count >= 600);
    @(posedge clk_i);
    hold_off_req = 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off_req = 1'b0;
  end

  // Watchdog.
  initial begin
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("timeout with %0d matrices outstanding", pending);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    logic [10:0] thr_set[4];
    thr_set = '{11'd0, 11'd1024, 11'd2047, 11'd40};
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: extremes, identity, opposite axes and the ties between components.
    send_vectors(16384, 0, 0, 16384, 0, 0);        // same direction
    send_vectors(16384, 0, 0, 0, 16384, 0);        // quarter turn about z
    send_vectors(0, 0, 16384, 0, 16384, 0);
    send_vectors(16384, 0, 0, -16384, 0, 0);       // opposite, y picked out
    send_vectors(0, 16384, 0, 0, -16384, 0);
    send_vectors(0, 0, -16384, 0, 0, 16384);
    send_vectors(9459, 9459, 9459, -9459, -9459, -9459); // all ties
    send_vectors(16384, 9000, 9000, -16384, -9000, -9000); // y against z tie
    send_vectors(0, 0, 0, 0, 0, 0);                // zero source: zero axis
    send_vectors(0, 0, 0, 16384, 0, 0);
    send_vectors(-32768, -32768, -32768, 32767, 32767, 32767); // cosine beyond range
    send_vectors(32767, -32768, 32767, -32768, 32767, -32768);
    send_vectors(-32768, 32767, 0, 32767, 32767, -32768);      // sine beyond one
    send_vectors(16384, 0, 0, 16384, 1, 0);        // tiny sine, threshold decides
    send_vectors(16384, 0, 0, -16384, 3, 0);
    send_vectors(11585, 11585, 0, -11585, 11585, 0);
    send_vectors(-16384, -16384, -16384, 16384, 16384, 16384);

    // Random phases across threshold settings; the pause drains everything.
    for (int ph = 0; ph < 4; ph++) begin
      quiesce_and_config(thr_set[ph]);
      for (int n = 0; n < RANDOM_ITEMS / 4; n++) send_random_pair();
      send_vectors(16384, 0, 0, 16384, 20, 0);
      send_vectors(16384, 0, 0, -16384, 20, 0);
    end
    quiesce_and_config(11'($urandom));
    for (int n = 0; n < 60; n++) send_random_pair();

    s_axis_tvalid <= 1'b0;
    stim_done = 1'b1;
    while (pending != 0) @(negedge clk_i);
    repeat (LATENCY + 10) @(negedge clk_i);

    $display("covered %0d matrices over thresholds 2, 0, 1024, 2047, 40 and a random one",
             matrix_count);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== vector_to_vector_rotation_matrix_top.f =====
rtl/core/vvr_pkg.sv
rtl/core/vector_to_vector_rotation_matrix_top.sv
tb/vector_to_vector_rotation_matrix_checker.sv
tb/vector_to_vector_rotation_matrix_top_tb.sv
